[rtl/core/qnl_pkg.sv]
// Shared types and fixed widths for the quaternion nlerp datapath.
package qnl_pkg;

    // Normalized magnitudes keep their top bit at position NORM_BITS-1.
    localparam int NORM_BITS = 30;
    localparam int SUM_BITS  = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS = NORM_BITS + 1;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic       near_parallel;
        logic [3:0] neg;
    } qnl_flags_t;

endpackage

[rtl/core/qnl_front.sv]
// Front pipeline: products, blend, dot compare, normalizing shift, sum of squares.
module qnl_front #(
    parameter int FRAC_BITS = 14,
    parameter int COMP_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [FRAC_BITS:0]                     thr,
    input  logic signed [COMP_BITS-1:0]            a_x,
    input  logic signed [COMP_BITS-1:0]            a_y,
    input  logic signed [COMP_BITS-1:0]            a_z,
    input  logic signed [COMP_BITS-1:0]            a_w,
    input  logic signed [COMP_BITS-1:0]            b_x,
    input  logic signed [COMP_BITS-1:0]            b_y,
    input  logic signed [COMP_BITS-1:0]            b_z,
    input  logic signed [COMP_BITS-1:0]            b_w,
    input  logic [FRAC_BITS:0]                     blend_t,
    output qnl_pkg::qnl_flags_t                    flags_out,
    output logic [qnl_pkg::SUM_BITS-1:0]           sum_out,
    output logic [3:0][qnl_pkg::NORM_BITS-1:0]     mag_out
);

    localparam int C  = COMP_BITS;
    localparam int F  = FRAC_BITS;
    localparam int MW = C + F + 2;
    localparam int MB = C + F;
    localparam int PW = $clog2(MB);
    localparam int DW = 2 * C + 2 * F + 2;
    localparam int NB = qnl_pkg::NORM_BITS;
    localparam int SB = qnl_pkg::SUM_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // stage 1: input capture
    logic               v1_reg;
    logic signed [C-1:0] a1_reg [4];
    logic signed [C-1:0] b1_reg [4];
    logic [F:0]          t1_reg;
    logic [F:0]          t_sat;

    // stage 2: products
    logic                  v2_reg;
    logic signed [2*C-1:0] pa2_reg [4];
    logic signed [MW-1:0]  ma2_reg [4];
    logic signed [MW-1:0]  mb2_reg [4];
    logic [F:0]            omt;

    // stage 3: dot sum and blend magnitudes
    logic                 v3_reg;
    logic signed [DW-1:0] dot3_reg;
    logic [MB-1:0]        mag3_reg [4];
    logic [3:0]           neg3_reg;
    logic signed [DW-1:0] dot_next;
    logic signed [MW-1:0] m_next [4];
    logic signed [MW-1:0] am_next [4];

    // stage 4: compare and leading-one position
    qnl_pkg::qnl_flags_t f4_reg;
    logic [PW-1:0]       lead4_reg;
    logic [MB-1:0]       mag4_reg [4];
    logic signed [DW-1:0] thr_s;
    logic [MB-1:0]       or_mag;
    logic [PW-1:0]       lead_next;

    // stage 5: normalized magnitudes
    qnl_pkg::qnl_flags_t f5_reg;
    logic [NB-1:0]       mag5_reg [4];
    logic [MB+NB-2:0]    wide [4];

    // stage 6: squares
    qnl_pkg::qnl_flags_t f6_reg;
    logic [NB-1:0]       mag6_reg [4];
    logic [2*NB-1:0]     sq6_reg [4];

    // stage 7: sum of squares
    qnl_pkg::qnl_flags_t f7_reg;
    logic [NB-1:0]       mag7_reg [4];
    logic [SB-1:0]       sum7_reg;

    assign t_sat = (blend_t > ONE) ? ONE : blend_t;
    assign omt   = ONE - t1_reg;

    always_comb
    begin
        dot_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            dot_next   = dot_next + DW'(pa2_reg[k]);
            m_next[k]  = ma2_reg[k] + mb2_reg[k];
            am_next[k] = m_next[k][MW-1] ? -m_next[k] : m_next[k];
        end
    end

    always_comb
    begin
        thr_s     = $signed(DW'({thr, {F{1'b0}}}));
        or_mag    = mag3_reg[0] | mag3_reg[1] | mag3_reg[2] | mag3_reg[3];
        lead_next = '0;
        for (int i = 0; i < MB; i++)
        begin
            if (or_mag[i])
                lead_next = PW'(i);
        end
    end

    // top bit lands at NB-1; lower bits drop when the shift goes right
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            wide[k] = {mag4_reg[k], {(NB-1){1'b0}}} >> lead4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            f4_reg <= '0;
            f5_reg <= '0;
            f6_reg <= '0;
            f7_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            f4_reg.valid         <= v3_reg;
            f4_reg.degenerate    <= (or_mag == '0);
            f4_reg.near_parallel <= (dot3_reg > thr_s);
            f4_reg.neg           <= neg3_reg;
            f5_reg <= f4_reg;
            f6_reg <= f5_reg;
            f7_reg <= f6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg[0] <= a_x;
            a1_reg[1] <= a_y;
            a1_reg[2] <= a_z;
            a1_reg[3] <= a_w;
            b1_reg[0] <= b_x;
            b1_reg[1] <= b_y;
            b1_reg[2] <= b_z;
            b1_reg[3] <= b_w;
            t1_reg    <= t_sat;
            for (int k = 0; k < 4; k++)
            begin
                pa2_reg[k]  <= a1_reg[k] * b1_reg[k];
                ma2_reg[k]  <= MW'(a1_reg[k]) * MW'($signed({1'b0, omt}));
                mb2_reg[k]  <= MW'(b1_reg[k]) * MW'($signed({1'b0, t1_reg}));
                mag3_reg[k] <= am_next[k][MB-1:0];
                neg3_reg[k] <= m_next[k][MW-1];
                mag4_reg[k] <= mag3_reg[k];
                mag5_reg[k] <= wide[k][NB-1:0];
                mag6_reg[k] <= mag5_reg[k];
                sq6_reg[k]  <= mag5_reg[k] * mag5_reg[k];
                mag7_reg[k] <= mag6_reg[k];
            end
            dot3_reg  <= dot_next;
            lead4_reg <= lead_next;
            sum7_reg  <= SB'(sq6_reg[0]) + SB'(sq6_reg[1])
                       + SB'(sq6_reg[2]) + SB'(sq6_reg[3]);
        end
    end

    assign flags_out = f7_reg;
    assign sum_out   = sum7_reg;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            mag_out[k] = mag7_reg[k];
    end

endmodule

[rtl/core/qnl_sqrt_cell.sv]
// One restoring square-root cell: settles a single root bit per stage.
module qnl_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  qnl_pkg::qnl_flags_t                flags_in,
    input  logic [qnl_pkg::SUM_BITS-1:0]       rem_in,
    input  logic [qnl_pkg::ROOT_BITS-1:0]      root_in,
    input  logic [3:0][qnl_pkg::NORM_BITS-1:0] mag_in,
    output qnl_pkg::qnl_flags_t                flags_out,
    output logic [qnl_pkg::SUM_BITS-1:0]       rem_out,
    output logic [qnl_pkg::ROOT_BITS-1:0]      root_out,
    output logic [3:0][qnl_pkg::NORM_BITS-1:0] mag_out
);

    localparam int SB = qnl_pkg::SUM_BITS;
    localparam int RB = qnl_pkg::ROOT_BITS;

    qnl_pkg::qnl_flags_t                flags_reg;
    logic [SB-1:0]                      rem_reg;
    logic [RB-1:0]                      root_reg;
    logic [3:0][qnl_pkg::NORM_BITS-1:0] mag_reg;

    logic [SB+1:0] trial;
    logic          take;
    logic [SB-1:0] rem_next;
    logic [RB-1:0] root_next;

    // (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
    always_comb
    begin
        trial     = ((SB+2)'(root_in) << (BIT_POS + 1)) + ((SB+2)'(1) << (2 * BIT_POS));
        take      = {2'b00, rem_in} >= trial;
        rem_next  = take ? rem_in - trial[SB-1:0] : rem_in;
        root_next = take ? (root_in | (RB'(1) << BIT_POS)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (en)
            flags_reg <= flags_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            mag_reg  <= mag_in;
        end
    end

    assign flags_out = flags_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign mag_out   = mag_reg;

endmodule

[rtl/core/qnl_div_cell.sv]
// One restoring divide cell: settles a single quotient bit in each of four lanes.
module qnl_div_cell #(
    parameter int FRAC_BITS = 14,
    parameter int BIT_POS   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  qnl_pkg::qnl_flags_t           flags_in,
    input  logic [qnl_pkg::ROOT_BITS-1:0] root_in,
    input  logic [3:0][FRAC_BITS+31:0]    rem_in,
    input  logic [3:0][FRAC_BITS:0]       quo_in,
    output qnl_pkg::qnl_flags_t           flags_out,
    output logic [qnl_pkg::ROOT_BITS-1:0] root_out,
    output logic [3:0][FRAC_BITS+31:0]    rem_out,
    output logic [3:0][FRAC_BITS:0]       quo_out
);

    localparam int NW = FRAC_BITS + 32;
    localparam int QW = FRAC_BITS + 1;

    qnl_pkg::qnl_flags_t           flags_reg;
    logic [qnl_pkg::ROOT_BITS-1:0] root_reg;
    logic [3:0][NW-1:0]            rem_reg;
    logic [3:0][QW-1:0]            quo_reg;

    logic [NW-1:0]      dsh;
    logic [3:0][NW-1:0] rem_next;
    logic [3:0][QW-1:0] quo_next;

    always_comb
    begin
        dsh = NW'(root_in) << BIT_POS;
        for (int k = 0; k < 4; k++)
        begin
            if (rem_in[k] >= dsh)
            begin
                rem_next[k] = rem_in[k] - dsh;
                quo_next[k] = quo_in[k] | (QW'(1) << BIT_POS);
            end
            else
            begin
                rem_next[k] = rem_in[k];
                quo_next[k] = quo_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (en)
            flags_reg <= flags_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= root_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign flags_out = flags_reg;
    assign root_out  = root_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

[rtl/core/quaternion_normalised_lerp_unit.sv]
// Quaternion normalized lerp: blend, length via square-root cells, divide cells.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  config   | cfg_wr_en          | cfg_wr_data (parallel threshold)
//  input    | in_valid/in_stall  | a_x..a_w, b_x..b_w, blend_t
//  output   | out_valid/out_stall| r_x..r_w, near_parallel, degenerate
//
// One beat per cycle in and out while the output is not stalled; the chain runs through
// the front stages, the 31 square-root cells and FRAC_BITS+1 divide cells.
// The whole chain advances together; an output stall while out_valid is high freezes it and raises in_stall.
// Reset clears valid bits and loads the threshold with about 0.9995.
module quaternion_normalised_lerp_unit #(
    parameter int FRAC_BITS = 14,
    parameter int COMP_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [FRAC_BITS:0]           cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COMP_BITS-1:0]  a_x,
    input  logic signed [COMP_BITS-1:0]  a_y,
    input  logic signed [COMP_BITS-1:0]  a_z,
    input  logic signed [COMP_BITS-1:0]  a_w,
    input  logic signed [COMP_BITS-1:0]  b_x,
    input  logic signed [COMP_BITS-1:0]  b_y,
    input  logic signed [COMP_BITS-1:0]  b_z,
    input  logic signed [COMP_BITS-1:0]  b_w,
    input  logic [FRAC_BITS:0]           blend_t,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [FRAC_BITS+1:0]  r_x,
    output logic signed [FRAC_BITS+1:0]  r_y,
    output logic signed [FRAC_BITS+1:0]  r_z,
    output logic signed [FRAC_BITS+1:0]  r_w,
    output logic                         near_parallel,
    output logic                         degenerate
);

    localparam int F  = FRAC_BITS;
    localparam int NB = qnl_pkg::NORM_BITS;
    localparam int SB = qnl_pkg::SUM_BITS;
    localparam int RB = qnl_pkg::ROOT_BITS;
    localparam int NW = F + 32;
    localparam int QW = F + 1;
    localparam logic [F:0] ONE = QW'(1) << F;
    localparam logic [F:0] THR_RESET =
        QW'((((longint'(1)) << F) * 64'd9995 + 64'd5000) / 64'd10000);

    logic       adv;
    logic [F:0] thr_reg;

    qnl_pkg::qnl_flags_t            sq_flags [RB+1];
    logic [SB-1:0]                  sq_rem   [RB+1];
    logic [RB-1:0]                  sq_root  [RB+1];
    logic [3:0][NB-1:0]             sq_mag   [RB+1];

    qnl_pkg::qnl_flags_t            pr_flags_reg;
    logic [RB-1:0]                  pr_root_reg;
    logic [3:0][NW-1:0]             pr_rem_reg;

    qnl_pkg::qnl_flags_t            dv_flags [QW+1];
    logic [RB-1:0]                  dv_root  [QW+1];
    logic [3:0][NW-1:0]             dv_rem   [QW+1];
    logic [3:0][QW-1:0]             dv_quo   [QW+1];

    logic                           out_valid_reg;
    logic                           np_reg;
    logic                           deg_reg;
    logic signed [F+1:0]            r_reg [4];
    logic signed [F+1:0]            r_next [4];
    logic [F:0]                     qsat;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    qnl_front #(
        .FRAC_BITS (FRAC_BITS),
        .COMP_BITS (COMP_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .thr       (thr_reg),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .a_w       (a_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .b_w       (b_w),
        .blend_t   (blend_t),
        .flags_out (sq_flags[0]),
        .sum_out   (sq_rem[0]),
        .mag_out   (sq_mag[0])
    );

    assign sq_root[0] = '0;

    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        qnl_sqrt_cell #(
            .BIT_POS (RB - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .flags_in  (sq_flags[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .mag_in    (sq_mag[k]),
            .flags_out (sq_flags[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .mag_out   (sq_mag[k+1])
        );
    end

    // numerator mag * 2^F + floor(L/2) gives round half up on the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_flags_reg <= '0;
        else if (adv)
            pr_flags_reg <= sq_flags[RB];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_root_reg <= sq_root[RB];
            for (int k = 0; k < 4; k++)
                pr_rem_reg[k] <= (NW'(sq_mag[RB][k]) << F) + NW'(sq_root[RB] >> 1);
        end
    end

    assign dv_flags[0] = pr_flags_reg;
    assign dv_root[0]  = pr_root_reg;
    assign dv_rem[0]   = pr_rem_reg;
    assign dv_quo[0]   = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        qnl_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (F - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .flags_in  (dv_flags[k]),
            .root_in   (dv_root[k]),
            .rem_in    (dv_rem[k]),
            .quo_in    (dv_quo[k]),
            .flags_out (dv_flags[k+1]),
            .root_out  (dv_root[k+1]),
            .rem_out   (dv_rem[k+1]),
            .quo_out   (dv_quo[k+1])
        );
    end

    always_comb
    begin
        qsat = '0;
        for (int k = 0; k < 4; k++)
        begin
            qsat = (dv_quo[QW][k] > ONE) ? ONE : dv_quo[QW][k];
            if (dv_flags[QW].degenerate)
                r_next[k] = '0;
            else if (dv_flags[QW].neg[k])
                r_next[k] = -$signed({1'b0, qsat});
            else
                r_next[k] = $signed({1'b0, qsat});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_flags[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            np_reg  <= dv_flags[QW].near_parallel;
            deg_reg <= dv_flags[QW].degenerate;
            for (int k = 0; k < 4; k++)
                r_reg[k] <= r_next[k];
        end
    end

    assign out_valid     = out_valid_reg;
    assign r_x           = r_reg[0];
    assign r_y           = r_reg[1];
    assign r_z           = r_reg[2];
    assign r_w           = r_reg[3];
    assign near_parallel = np_reg;
    assign degenerate    = deg_reg;

endmodule

[rtl/core/qnl_checker.sv]
// Port-level checks on the nlerp unit's result channel, bound to the top level.
module qnl_port_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [FRAC_BITS+1:0] r_x,
    input logic signed [FRAC_BITS+1:0] r_y,
    input logic signed [FRAC_BITS+1:0] r_z,
    input logic signed [FRAC_BITS+1:0] r_w,
    input logic                        degenerate
);

    localparam logic signed [FRAC_BITS+1:0] ONE  = (FRAC_BITS+2)'(1) << FRAC_BITS;
    localparam logic signed [FRAC_BITS+1:0] MONE = -ONE;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(r_x) && $stable(r_w)
            && $stable(degenerate))
        else $error("stalled result beat changed");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> r_x == 0 && r_y == 0 && r_z == 0 && r_w == 0)
        else $error("degenerate beat carries nonzero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> r_x <= ONE && r_x >= MONE && r_y <= ONE && r_y >= MONE
            && r_z <= ONE && r_z >= MONE && r_w <= ONE && r_w >= MONE)
        else $error("result component outside unit range");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind quaternion_normalised_lerp_unit qnl_port_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_qnl_checker (.*);

[dv/qnl_checker.sv]
// Watches the nlerp unit's channels, predicts each result and compares it.
module qnl_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] a_w,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] b_w,
    input  logic [14:0]        blend_t,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] r_x,
    input  logic signed [15:0] r_y,
    input  logic signed [15:0] r_z,
    input  logic signed [15:0] r_w,
    input  logic               near_parallel,
    input  logic               degenerate,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] q[4];
        logic               par;
        logic               degen;
    } unit_quat_t;

    unit_quat_t  unit_q[$];
    logic [14:0] thr_shadow;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic unit_quat_t nlerp(logic signed [15:0] a[4], logic signed [15:0] b[4],
                                         logic [14:0] t_raw, logic [14:0] thr);
        unit_quat_t      res;
        longint          dot;
        longint          t;
        longint          m;
        longint unsigned mag[4];
        logic            neg[4];
        longint unsigned maxm;
        longint unsigned s;
        longint unsigned len;
        longint unsigned r;
        dot  = 0;
        maxm = 0;
        t    = (t_raw > 15'd16384) ? 16384 : longint'(t_raw);
        for (int k = 0; k < 4; k++)
            dot += longint'(a[k]) * longint'(b[k]);
        res.par   = dot > (longint'(thr) << 14);
        res.degen = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            m      = longint'(a[k]) * (16384 - t) + longint'(b[k]) * t;
            neg[k] = m < 0;
            mag[k] = neg[k] ? longint'(-m) : m;
            if (mag[k] > maxm)
                maxm = mag[k];
        end
        if (maxm == 0)
        begin
            for (int k = 0; k < 4; k++)
                res.q[k] = '0;
            res.degen = 1'b1;
            return res;
        end
        while (maxm >= (64'd1 << 30))
        begin
            maxm >>= 1;
            for (int k = 0; k < 4; k++)
                mag[k] >>= 1;
        end
        while (maxm < (64'd1 << 29))
        begin
            maxm <<= 1;
            for (int k = 0; k < 4; k++)
                mag[k] <<= 1;
        end
        s = 0;
        for (int k = 0; k < 4; k++)
            s += mag[k] * mag[k];
        len = int_sqrt(s);
        for (int k = 0; k < 4; k++)
        begin
            r = ((mag[k] << 14) + (len >> 1)) / len;
            if (r > 16384)
                r = 16384;
            res.q[k] = neg[k] ? -16'(r) : 16'(r);
        end
        return res;
    endfunction

    assign pending = unit_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] a[4];
        logic signed [15:0] b[4];
        logic signed [15:0] got[4];
        unit_quat_t         exp_q;
        if (!rst_n)
        begin
            thr_shadow   <= 15'd16376;
            fail_count   <= 0;
            result_count <= 0;
            unit_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                a = '{a_x, a_y, a_z, a_w};
                b = '{b_x, b_y, b_z, b_w};
                unit_q.push_back(nlerp(a, b, blend_t, thr_shadow));
            end
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                got = '{r_x, r_y, r_z, r_w};
                if (unit_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_q = unit_q.pop_front();
                    if (got != exp_q.q || near_parallel !== exp_q.par
                        || degenerate !== exp_q.degen)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp %0d %0d %0d %0d p%0b d%0b",
                                      " got %0d %0d %0d %0d p%0b d%0b"},
                                     $realtime, exp_q.q[0], exp_q.q[1], exp_q.q[2],
                                     exp_q.q[3], exp_q.par, exp_q.degen, got[0], got[1],
                                     got[2], got[3], near_parallel, degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_wr_en)
                thr_shadow <= cfg_wr_data;
        end
    end
endmodule

[dv/tb_top.sv]
// Stimulus and verdict for the quaternion nlerp unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 55;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [14:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
    logic signed [15:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
    logic [14:0]        blend_t = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic               near_parallel, degenerate;
    int                 fail_count, pending, result_count;
    bit                 quiet = 1'b0;
    int                 stall_left = 0;

    always #5 clk = ~clk;

    quaternion_normalised_lerp_unit u_dut (.*);
    qnl_checker u_chk (.*);

    // out_stall bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_pair(logic signed [15:0] a[4], logic signed [15:0] b[4],
                             logic [14:0] t);
        bit stalled;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        {a_x, a_y, a_z, a_w} <= {a[0], a[1], a[2], a[3]};
        {b_x, b_y, b_z, b_w} <= {b[0], b[1], b[2], b[3]};
        blend_t  <= t;
        in_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic rand_pairs(int n);
        logic signed [15:0] a[4];
        logic signed [15:0] b[4];
        logic [14:0]        t;
        int                 kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 4; k++)
            begin
                if (kind < 5)
                begin
                    // roughly unit inputs, b close to a for near-parallel hits
                    a[k] = 16'($urandom_range(0, 16384) - 8192);
                    b[k] = a[k] + 16'($urandom_range(0, 64) - 32);
                end
                else if (kind < 8)
                begin
                    a[k] = 16'($urandom_range(0, 32767) - 16384);
                    b[k] = 16'($urandom_range(0, 32767) - 16384);
                end
                else
                begin
                    a[k] = 16'($urandom);
                    b[k] = (kind == 9) ? -a[k] : 16'($urandom);
                end
            end
            t = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
            send_pair(a, b, t);
        end
    endtask

    initial
    begin
        logic signed [15:0] zq[4];
        logic signed [15:0] mx[4];
        logic signed [15:0] mn[4];
        logic signed [15:0] uw[4];
        logic signed [15:0] ux[4];
        zq = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        mx = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        mn = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        uw = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        ux = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, extremes, t ends, t saturation, parallel pairs
        send_pair(zq, zq, 15'd0);
        send_pair(zq, zq, 15'd8192);
        send_pair(mx, mn, 15'd8192);
        send_pair(mn, mx, 15'd8192);
        send_pair(mx, mx, 15'd0);
        send_pair(mn, mn, 15'd16384);
        send_pair(mx, mn, 15'd0);
        send_pair(mx, mn, 15'd16384);
        send_pair(mx, mn, 15'd32767);
        send_pair(uw, ux, 15'd16385);
        send_pair(uw, ux, 15'd8192);
        send_pair(uw, uw, 15'd1);
        send_pair(ux, uw, 15'd16383);
        send_pair('{16'sd1, 16'sd0, 16'sd0, 16'sd0}, zq, 15'd0);
        send_pair(zq, '{16'sd0, -16'sd1, 16'sd0, 16'sd0}, 15'd16384);
        send_pair('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8191}, uw, 15'd0);
        send_pair('{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, uw, 15'd4096);
        drain();

        write_threshold(15'd0);
        send_pair(uw, ux, 15'd8192);
        send_pair(ux, '{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 15'd100);
        rand_pairs(80);
        drain();
        write_threshold(15'd16384);
        send_pair(mx, mx, 15'd0);
        rand_pairs(80);
        drain();
        write_threshold(15'd32767);
        send_pair(mn, mn, 15'd0);
        rand_pairs(80);
        drain();
        write_threshold(15'd16376);
        rand_pairs(80);
        drain();
        write_threshold(15'($urandom_range(16000, 16384)));
        rand_pairs(60);
        quiet = 1'b1;
        rand_pairs(60);
        drain();

        $display("Ran %0d nlerp results over five threshold settings,", result_count);
        $display("with degenerate, saturating and near-parallel pairs under random stalls.");
        if (fail_count == 0)
            $display("** quaternion_normalised_lerp_unit: PASSED **");
        else
            $display("** quaternion_normalised_lerp_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results still outstanding", pending);
        $display("** quaternion_normalised_lerp_unit: FAILED **");
        $finish;
    end
endmodule
